// ===== hw/rtl/dcb_pkg.sv =====
// Shared types and constants of the draw call batcher.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package dcb_pkg;

    // Field widths of the draw and result items.
    localparam int SHADER_W = 16;
    localparam int BLEND_W  = 4;
    localparam int TEX_W    = 32;
    localparam int IDX_W    = 32;
    localparam int CMD_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int USED_W   = 4;

    localparam int DEFAULT_TEXTURE_SLOTS = 8;

    // Draw item opcodes.
    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Control from the sequencer to the slot scanner.
    typedef struct packed {
        logic start;   // begin a scan for the held key
        logic write;   // bind a texture to a slot
    } dcb_scan_ctl_t;

    // Status from the slot scanner.
    typedef struct packed {
        logic done;    // scan finished, hit is valid
        logic hit;     // key found among the bound slots
    } dcb_scan_sts_t;

endpackage : dcb_pkg

`default_nettype wire

// ===== hw/rtl/dcb_in_if.sv =====
// Draw item channel: valid/ready handshake plus the draw fields.
// Depends on dcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dcb_in_if
    import dcb_pkg::*;
();

    logic                valid;
    logic                ready;
    logic                op;
    logic [SHADER_W-1:0] shader_id;
    logic [BLEND_W-1:0]  blend_mode;
    logic [TEX_W-1:0]    texture_id;
    logic                uniforms_dirty;
    logic [IDX_W-1:0]    span_base_index;
    logic [IDX_W-1:0]    span_index_cursor;

    modport source (
        output valid, op, shader_id, blend_mode, texture_id, uniforms_dirty,
               span_base_index, span_index_cursor,
        input  ready
    );

    modport sink (
        input  valid, op, shader_id, blend_mode, texture_id, uniforms_dirty,
               span_base_index, span_index_cursor,
        output ready
    );

endinterface : dcb_in_if

`default_nettype wire

// ===== hw/rtl/dcb_out_if.sv =====
// Result item channel: valid/ready handshake plus the result fields.
// Depends on dcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dcb_out_if
    import dcb_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              opened_new;
    logic [CMD_W-1:0]  command_number;
    logic [IDX_W-1:0]  cmd_index_start;
    logic [IDX_W-1:0]  cmd_index_count;
    logic [SLOT_W-1:0] slot_index;
    logic [USED_W-1:0] slots_used;

    modport source (
        output valid, opened_new, command_number, cmd_index_start,
               cmd_index_count, slot_index, slots_used,
        input  ready
    );

    modport sink (
        input  valid, opened_new, command_number, cmd_index_start,
               cmd_index_count, slot_index, slots_used,
        output ready
    );

endinterface : dcb_out_if

`default_nettype wire

// ===== hw/rtl/draw_call_batcher_core.sv =====
// Draw call batcher top level: sequencer, command state and result register.
// Depends on dcb_pkg, dcb_in_if, dcb_out_if and dcb_slot_scan.
//
// Usage:
//   draw   (sink)   : one draw item per handshake. op = submit merges the draw
//                     into the current command or opens a new one; op = clear
//                     empties the command list and yields no result.
//   result (source) : one result item per submitted draw, in order.
// Timing: a clear item is handled in ST_IDLE and leaves draw.ready high. A submit
//   passes ST_SCAN, where the shared slot comparator checks one bound texture slot
//   per cycle, stopping early on a hit, then ST_FINISH evaluates the merge and
//   writes the result register. draw.ready is low while an item is in work.
// Stall: the result register holds a finished item until result.ready; the
//   next draw item is accepted meanwhile and its scan runs, but its result
//   waits in the final step until the register is free.
// Reset: asynchronous, active low. The command list is empty, the command
//   counter is zero and no result is pending. Slot contents are not cleared;
//   only slots below the bound count are ever compared.
`timescale 1ns / 1ps
`default_nettype none

module draw_call_batcher_core
    import dcb_pkg::*;
#(
    parameter int TEXTURE_SLOTS = DEFAULT_TEXTURE_SLOTS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dcb_in_if.sink    draw,
    dcb_out_if.source result
);

    localparam int CW = $clog2(TEXTURE_SLOTS + 1);
    localparam int IW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Command state
    logic                have_cmd_reg, have_cmd_next;
    logic [SHADER_W-1:0] cur_shader_reg, cur_shader_next;
    logic [BLEND_W-1:0]  cur_blend_reg, cur_blend_next;
    logic [CW-1:0]       slot_count_reg, slot_count_next;
    logic [IDX_W-1:0]    start_index_reg, start_index_next;
    logic [IDX_W-1:0]    index_total_reg, index_total_next;
    logic [CMD_W-1:0]    cmd_counter_reg, cmd_counter_next;

    // Draw item in work
    logic [SHADER_W-1:0] item_shader_reg, item_shader_next;
    logic [BLEND_W-1:0]  item_blend_reg, item_blend_next;
    logic [TEX_W-1:0]    item_tex_reg, item_tex_next;
    logic                item_dirty_reg, item_dirty_next;
    logic [IDX_W-1:0]    item_base_reg, item_base_next;
    logic [IDX_W-1:0]    item_span_reg, item_span_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                out_opened_reg, out_opened_next;
    logic [CMD_W-1:0]    out_cmd_reg, out_cmd_next;
    logic [IDX_W-1:0]    out_start_reg, out_start_next;
    logic [IDX_W-1:0]    out_count_reg, out_count_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [USED_W-1:0]   out_used_reg, out_used_next;

    // Slot scanner hookup
    dcb_scan_ctl_t       scan_ctl;
    dcb_scan_sts_t       scan_sts;
    logic [IW-1:0]       scan_hit_idx;
    logic [IW-1:0]       wr_addr;

    logic                hdr_match;
    logic                has_room;
    logic                merge;
    logic                accept;
    logic [IW-1:0]       slot_sel;
    logic [31:0]         slot_wide;
    logic [31:0]         used_wide;

    dcb_slot_scan #(
        .SLOTS (TEXTURE_SLOTS)
    ) u_slot_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .key     (item_tex_reg),
        .limit   (slot_count_reg),
        .wr_addr (wr_addr),
        .wr_data (item_tex_reg),
        .sts     (scan_sts),
        .hit_idx (scan_hit_idx)
    );

    assign draw.ready = (state_reg == ST_IDLE);
    assign accept     = draw.valid && draw.ready;

    // Join test: same shader and blend, clean uniforms, texture bound or a slot free.
    assign hdr_match = have_cmd_reg && (item_shader_reg == cur_shader_reg) &&
                       (item_blend_reg == cur_blend_reg) && !item_dirty_reg;
    assign has_room  = scan_sts.hit || (slot_count_reg < CW'(TEXTURE_SLOTS));
    assign merge     = hdr_match && has_room;

    // Result fields keep the low bits of wider slot values.
    assign slot_wide = 32'(slot_sel);
    assign used_wide = 32'(slot_count_next);

    always_comb
    begin
        state_next       = state_reg;
        have_cmd_next    = have_cmd_reg;
        cur_shader_next  = cur_shader_reg;
        cur_blend_next   = cur_blend_reg;
        slot_count_next  = slot_count_reg;
        start_index_next = start_index_reg;
        index_total_next = index_total_reg;
        cmd_counter_next = cmd_counter_reg;

        item_shader_next = item_shader_reg;
        item_blend_next  = item_blend_reg;
        item_tex_next    = item_tex_reg;
        item_dirty_next  = item_dirty_reg;
        item_base_next   = item_base_reg;
        item_span_next   = item_span_reg;

        out_valid_next   = out_valid_reg && !result.ready;
        out_opened_next  = out_opened_reg;
        out_cmd_next     = out_cmd_reg;
        out_start_next   = out_start_reg;
        out_count_next   = out_count_reg;
        out_slot_next    = out_slot_reg;
        out_used_next    = out_used_reg;

        scan_ctl         = '0;
        wr_addr          = '0;
        slot_sel         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (draw.op == OP_CLEAR)
                    begin
                        have_cmd_next    = 1'b0;
                        slot_count_next  = '0;
                        start_index_next = '0;
                        index_total_next = '0;
                        cmd_counter_next = '0;
                    end
                    else
                    begin
                        item_shader_next = draw.shader_id;
                        item_blend_next  = draw.blend_mode;
                        item_tex_next    = draw.texture_id;
                        item_dirty_next  = draw.uniforms_dirty;
                        item_base_next   = draw.span_base_index;
                        item_span_next   = draw.span_index_cursor - draw.span_base_index;
                        scan_ctl.start   = 1'b1;
                        state_next       = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_sts.done)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    if (!merge)
                    begin
                        // New command; its first slot takes this texture.
                        cmd_counter_next = have_cmd_reg ? cmd_counter_reg + CMD_W'(1) : '0;
                        have_cmd_next    = 1'b1;
                        cur_shader_next  = item_shader_reg;
                        cur_blend_next   = item_blend_reg;
                        start_index_next = item_base_reg;
                        index_total_next = item_span_reg;
                        slot_count_next  = CW'(1);
                        scan_ctl.write   = 1'b1;
                        wr_addr          = '0;
                        slot_sel         = '0;
                    end
                    else
                    begin
                        index_total_next = index_total_reg + item_span_reg;
                        if (scan_sts.hit)
                        begin
                            slot_sel = scan_hit_idx;
                        end
                        else
                        begin
                            // Bind to the next free slot.
                            scan_ctl.write  = 1'b1;
                            wr_addr         = slot_count_reg[IW-1:0];
                            slot_sel        = slot_count_reg[IW-1:0];
                            slot_count_next = slot_count_reg + CW'(1);
                        end
                    end

                    out_valid_next  = 1'b1;
                    out_opened_next = !merge;
                    out_cmd_next    = cmd_counter_next;
                    out_start_next  = start_index_next;
                    out_count_next  = index_total_next;
                    out_slot_next   = slot_wide[SLOT_W-1:0];
                    out_used_next   = used_wide[USED_W-1:0];
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            have_cmd_reg    <= 1'b0;
            cur_shader_reg  <= '0;
            cur_blend_reg   <= '0;
            slot_count_reg  <= '0;
            start_index_reg <= '0;
            index_total_reg <= '0;
            cmd_counter_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            have_cmd_reg    <= have_cmd_next;
            cur_shader_reg  <= cur_shader_next;
            cur_blend_reg   <= cur_blend_next;
            slot_count_reg  <= slot_count_next;
            start_index_reg <= start_index_next;
            index_total_reg <= index_total_next;
            cmd_counter_reg <= cmd_counter_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_shader_reg <= item_shader_next;
        item_blend_reg  <= item_blend_next;
        item_tex_reg    <= item_tex_next;
        item_dirty_reg  <= item_dirty_next;
        item_base_reg   <= item_base_next;
        item_span_reg   <= item_span_next;
        out_opened_reg  <= out_opened_next;
        out_cmd_reg     <= out_cmd_next;
        out_start_reg   <= out_start_next;
        out_count_reg   <= out_count_next;
        out_slot_reg    <= out_slot_next;
        out_used_reg    <= out_used_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.opened_new      = out_opened_reg;
    assign result.command_number  = out_cmd_reg;
    assign result.cmd_index_start = out_start_reg;
    assign result.cmd_index_count = out_count_reg;
    assign result.slot_index      = out_slot_reg;
    assign result.slots_used      = out_used_reg;

endmodule : draw_call_batcher_core

`default_nettype wire

// ===== hw/rtl/dcb_slot_scan.sv =====
// Texture slot table with a single shared comparator that scans one slot per cycle.
// Depends on dcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcb_slot_scan
    import dcb_pkg::*;
#(
    parameter int SLOTS = DEFAULT_TEXTURE_SLOTS,
    localparam int CW = $clog2(SLOTS + 1),
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dcb_scan_ctl_t ctl,
    input  wire logic [TEX_W-1:0] key,      // held stable during a scan
    input  wire logic [CW-1:0] limit,       // number of bound slots
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [TEX_W-1:0] wr_data,
    output dcb_scan_sts_t      sts,
    output logic [IW-1:0]      hit_idx
);

    logic [TEX_W-1:0] slot_tex_reg [SLOTS];
    logic [CW-1:0]    scan_idx_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             hit_reg;
    logic [IW-1:0]    hit_idx_reg;

    logic [IW-1:0]    cur_idx;
    logic             at_end;
    logic             match;

    assign cur_idx = scan_idx_reg[IW-1:0];
    assign at_end  = (scan_idx_reg == limit);
    assign match   = (slot_tex_reg[cur_idx] == key);

    // Slot contents: no reset, entries at or above limit are never compared.
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            slot_tex_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
        end
        else if (ctl.start)
        begin
            scan_idx_reg <= '0;
            busy_reg     <= 1'b1;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (match)
            begin
                busy_reg    <= 1'b0;
                done_reg    <= 1'b1;
                hit_reg     <= 1'b1;
                hit_idx_reg <= cur_idx;
            end
            else
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.hit  = hit_reg;
    assign hit_idx  = hit_idx_reg;

endmodule : dcb_slot_scan

`default_nettype wire
